[sv/rsfl_pkg.sv]
// rsfl_pkg: shared types and fixed field widths for the record slot allocator.
// No dependencies; imported by rsfl_store and record_slot_free_list_allocator.
package rsfl_pkg;

   // Fixed field widths of the ports
   localparam int CFG_W    = 7;
   localparam int OP_W     = 3;
   localparam int SLOT_W   = 7;
   localparam int STATUS_W = 3;
   localparam int RSLOT_W  = 6;
   localparam int DATA_W   = 64;
   localparam int COUNT_W  = 7;

   // Reset value of the slot limit register
   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   typedef enum logic [OP_W-1:0] {
      OP_INIT   = 3'd0,
      OP_INSERT = 3'd1,
      OP_DELETE = 3'd2,
      OP_GET    = 3'd3,
      OP_UPDATE = 3'd4,
      OP_SCAN   = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK         = 3'd0,
      STAT_NOT_IN_USE = 3'd1,
      STAT_FULL       = 3'd2,
      STAT_EOF        = 3'd3,
      STAT_RANGE      = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_READ,
      S_CHECK,
      S_DONE
   } state_type;

   // Write enables from the sequencer to the slot store
   typedef struct packed {
      logic tbl_we;
      logic rec_we;
   } store_ctl_type;

endpackage

[sv/rsfl_store.sv]
// rsfl_store: slot table (in-use flag plus free link) and record memory.
// Depends on rsfl_pkg. One write address, one read address, registered reads.
module rsfl_store #(
   parameter int SLOTS       = 64,
   parameter int RECORD_BITS = 64
) (
   input  logic                          clock,
   input  rsfl_pkg::store_ctl_type       ctl,
   input  logic [$clog2(SLOTS)-1:0]      wr_addr,
   input  logic [$clog2(SLOTS)-1:0]      rd_addr,
   input  logic                          tbl_wr_used,
   input  logic [$clog2(SLOTS+1)-1:0]    tbl_wr_link,
   input  logic [RECORD_BITS-1:0]        rec_wr_data,
   output logic                          tbl_rd_used,
   output logic [$clog2(SLOTS+1)-1:0]    tbl_rd_link,
   output logic [RECORD_BITS-1:0]        rec_rd_data
);
   import rsfl_pkg::*;

   localparam int LINK_W = $clog2(SLOTS + 1);

   logic [LINK_W:0]          tbl_mem [SLOTS];
   logic [RECORD_BITS-1:0]   rec_mem [SLOTS];
   logic [LINK_W:0]          tbl_rd_ff;
   logic [RECORD_BITS-1:0]   rec_rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.tbl_we) begin
         tbl_mem[wr_addr] <= {tbl_wr_used, tbl_wr_link};
      end
      tbl_rd_ff <= tbl_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (ctl.rec_we) begin
         rec_mem[wr_addr] <= rec_wr_data;
      end
      rec_rd_ff <= rec_mem[rd_addr];
   end

   assign tbl_rd_used = tbl_rd_ff[LINK_W];
   assign tbl_rd_link = tbl_rd_ff[LINK_W-1:0];
   assign rec_rd_data = rec_rd_ff;

endmodule

[sv/record_slot_free_list_allocator.sv]
// record_slot_free_list_allocator: top level, sequencer and result register.
// Depends on rsfl_pkg and rsfl_store.
//
// Allocates record slots on one page from a linked free list. Each slot has
// an in-use flag and a free link in a table memory and a record in a second
// memory; both have registered reads, so every slot access passes through a
// read state and a check/write state. Insert, delete, get and update go
// through accept, read, check and result load; requests rejected by range or
// count checks go from accept straight to result load. A scan repeats the
// read and check for each slot it visits, one table read per slot. Init
// rewrites the whole table, one entry per cycle. After reset the same pass
// runs with req_ready low; csr writes are taken at any time and the slot
// limit is sampled when a request transfers. The limit is the csr value
// saturated to 1..SLOTS. A new request is taken while a finished result
// still waits on rsp_*.
module record_slot_free_list_allocator #(
   parameter int SLOTS       = 64,
   parameter int RECORD_BITS = 64
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [rsfl_pkg::CFG_W-1:0]            csr_write_data,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [rsfl_pkg::OP_W-1:0]             req_op,
   input  logic signed [rsfl_pkg::SLOT_W-1:0]    req_slot,
   input  logic [rsfl_pkg::DATA_W-1:0]           req_write_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rsfl_pkg::STATUS_W-1:0]         rsp_status,
   output logic [rsfl_pkg::RSLOT_W-1:0]          rsp_result_slot,
   output logic [rsfl_pkg::DATA_W-1:0]           rsp_read_data,
   output logic [rsfl_pkg::COUNT_W-1:0]          rsp_record_count
);
   import rsfl_pkg::*;

   localparam int IDX_W  = $clog2(SLOTS);
   localparam int LINK_W = $clog2(SLOTS + 1);
   localparam int CMP_W  = (LINK_W > CFG_W) ? LINK_W : CFG_W;

   localparam logic [LINK_W-1:0] LINK_END  = LINK_W'(SLOTS);
   localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(SLOTS - 1);
   localparam logic [CMP_W-1:0]  SLOTS_CMP = CMP_W'(SLOTS);
   localparam logic [CMP_W-1:0]  LIM_RESET =
      (int'(CFG_RESET) > SLOTS) ? CMP_W'(SLOTS) : CMP_W'(int'(CFG_RESET));

   // Sequencer and datapath registers
   state_type               state_ff, state_in;
   logic [CFG_W-1:0]        cfg_ff;
   logic [OP_W-1:0]         op_ff, op_in;
   logic [RECORD_BITS-1:0]  wdata_ff, wdata_in;
   logic [CMP_W-1:0]        lim_ff, lim_in;
   logic [IDX_W-1:0]        addr_ff, addr_in;      // slot under work / sweep index
   logic [LINK_W-1:0]       head_ff, head_in;
   logic [COUNT_W-1:0]      count_ff, count_in;
   logic                    reply_ff, reply_in;    // init wants a result after sweep
   status_type              res_status_ff, res_status_in;
   logic [IDX_W-1:0]        res_slot_ff, res_slot_in;
   logic [RECORD_BITS-1:0]  res_data_ff, res_data_in;

   // Result register
   logic                    rsp_valid_ff;
   logic [STATUS_W-1:0]     rsp_status_ff;
   logic [RSLOT_W-1:0]      rsp_slot_ff;
   logic [DATA_W-1:0]       rsp_data_ff;
   logic [COUNT_W-1:0]      rsp_count_ff;

   // Store interface
   store_ctl_type           st_ctl;
   logic [IDX_W-1:0]        wr_addr;
   logic                    tbl_wr_used;
   logic [LINK_W-1:0]       tbl_wr_link;
   logic                    tbl_rd_used;
   logic [LINK_W-1:0]       tbl_rd_link;
   logic [RECORD_BITS-1:0]  rec_rd_data;

   // Decisions shared by the output and next-state logic
   logic                    go_sweep, go_read, go_done;
   logic                    sweep_last;
   logic                    rsp_load;

   logic [CMP_W-1:0]        cfg_ext;
   logic [CMP_W-1:0]        lim_now;
   logic [CMP_W-1:0]        slot_ext;
   logic [CMP_W-1:0]        scan_start;
   logic [CMP_W-1:0]        addr_next;
   logic [LINK_W-1:0]       idx_inc;

   // Limit is the register saturated to 1..SLOTS
   always_comb begin
      cfg_ext = CMP_W'(cfg_ff);
      if (cfg_ext == '0) begin
         lim_now = CMP_W'(1);
      end else if (cfg_ext > SLOTS_CMP) begin
         lim_now = SLOTS_CMP;
      end else begin
         lim_now = cfg_ext;
      end
   end

   assign slot_ext   = CMP_W'(req_slot[RSLOT_W-1:0]);
   assign scan_start = req_slot[SLOT_W-1] ? '0 : slot_ext + CMP_W'(1);
   assign addr_next  = CMP_W'(addr_ff) + CMP_W'(1);
   assign idx_inc    = LINK_W'(addr_ff) + LINK_W'(1);
   assign sweep_last = (addr_ff == IDX_LAST);
   assign rsp_load   = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);

   // Datapath control and register next values
   always_comb begin
      op_in         = op_ff;
      wdata_in      = wdata_ff;
      lim_in        = lim_ff;
      addr_in       = addr_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      reply_in      = reply_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_data_in   = res_data_ff;
      st_ctl        = '0;
      wr_addr       = addr_ff;
      tbl_wr_used   = 1'b0;
      tbl_wr_link   = idx_inc;
      go_sweep      = 1'b0;
      go_read       = 1'b0;
      go_done       = 1'b0;

      case (state_ff)
         S_SWEEP: begin
            // Rebuild the chain: free flag, link to next, limit-1 ends it
            st_ctl.tbl_we = 1'b1;
            if (CMP_W'(idx_inc) == lim_ff) begin
               tbl_wr_link = LINK_END;
            end
            addr_in = addr_ff + IDX_W'(1);
            if (sweep_last) begin
               head_in       = '0;
               count_in      = '0;
               reply_in      = 1'b0;
               res_status_in = STAT_OK;
               res_slot_in   = '0;
               res_data_in   = '0;
               go_done       = reply_ff;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               op_in         = req_op;
               wdata_in      = req_write_data[RECORD_BITS-1:0];
               lim_in        = lim_now;
               res_status_in = STAT_OK;
               res_slot_in   = '0;
               res_data_in   = '0;
               case (op_type'(req_op))
                  OP_INIT: begin
                     addr_in  = '0;
                     reply_in = 1'b1;
                     go_sweep = 1'b1;
                  end
                  OP_INSERT: begin
                     if (CMP_W'(count_ff) >= lim_now || CMP_W'(head_ff) >= lim_now) begin
                        res_status_in = STAT_FULL;
                        go_done       = 1'b1;
                     end else begin
                        addr_in = head_ff[IDX_W-1:0];
                        go_read = 1'b1;
                     end
                  end
                  OP_DELETE, OP_GET, OP_UPDATE: begin
                     if (req_slot[SLOT_W-1] || slot_ext >= lim_now) begin
                        res_status_in = STAT_RANGE;
                        go_done       = 1'b1;
                     end else begin
                        addr_in = slot_ext[IDX_W-1:0];
                        go_read = 1'b1;
                     end
                  end
                  OP_SCAN: begin
                     if (scan_start >= lim_now) begin
                        res_status_in = STAT_EOF;
                        go_done       = 1'b1;
                     end else begin
                        addr_in = scan_start[IDX_W-1:0];
                        go_read = 1'b1;
                     end
                  end
                  default: begin
                     go_done = 1'b1;   // unused op codes: no change, ok
                  end
               endcase
            end
         end

         S_READ: begin
            // table and record reads of addr_ff in flight
         end

         S_CHECK: begin
            case (op_type'(op_ff))
               OP_INSERT: begin
                  go_done = 1'b1;
                  if (tbl_rd_used) begin
                     res_status_in = STAT_FULL;
                  end else begin
                     st_ctl.tbl_we = 1'b1;
                     st_ctl.rec_we = 1'b1;
                     tbl_wr_used   = 1'b1;
                     tbl_wr_link   = tbl_rd_link;
                     head_in       = tbl_rd_link;
                     count_in      = count_ff + COUNT_W'(1);
                     res_slot_in   = addr_ff;
                  end
               end
               OP_DELETE: begin
                  go_done = 1'b1;
                  if (!tbl_rd_used) begin
                     res_status_in = STAT_NOT_IN_USE;
                  end else begin
                     // push on the free list, linked to the old head
                     st_ctl.tbl_we = 1'b1;
                     tbl_wr_used   = 1'b0;
                     tbl_wr_link   = head_ff;
                     head_in       = LINK_W'(addr_ff);
                     if (count_ff != '0) begin
                        count_in = count_ff - COUNT_W'(1);
                     end
                  end
               end
               OP_GET: begin
                  go_done = 1'b1;
                  if (!tbl_rd_used) begin
                     res_status_in = STAT_NOT_IN_USE;
                  end else begin
                     res_data_in = rec_rd_data;
                  end
               end
               OP_UPDATE: begin
                  go_done = 1'b1;
                  if (!tbl_rd_used) begin
                     res_status_in = STAT_NOT_IN_USE;
                  end else begin
                     st_ctl.rec_we = 1'b1;
                  end
               end
               OP_SCAN: begin
                  if (tbl_rd_used) begin
                     res_status_in = STAT_OK;
                     res_slot_in   = addr_ff;
                     res_data_in   = rec_rd_data;
                     go_done       = 1'b1;
                  end else if (addr_next >= lim_ff) begin
                     res_status_in = STAT_EOF;
                     go_done       = 1'b1;
                  end else begin
                     addr_in = addr_next[IDX_W-1:0];
                     go_read = 1'b1;
                  end
               end
               default: begin
                  go_done = 1'b1;
               end
            endcase
         end

         S_DONE: begin
            // waiting for the result register
         end

         default: begin
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_SWEEP: begin
            if (sweep_last) begin
               state_in = go_done ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (go_sweep) begin
               state_in = S_SWEEP;
            end else if (go_read) begin
               state_in = S_READ;
            end else if (go_done) begin
               state_in = S_DONE;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (go_read) begin
               state_in = S_READ;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         cfg_ff   <= CFG_RESET;
         lim_ff   <= LIM_RESET;
         addr_ff  <= '0;
         head_ff  <= '0;
         count_ff <= '0;
         reply_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            cfg_ff <= csr_write_data;
         end
         lim_ff   <= lim_in;
         addr_ff  <= addr_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         reply_ff <= reply_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      wdata_ff      <= wdata_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_data_ff   <= res_data_in;
   end

   // Result register: loads from the staged result when empty or draining
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= RSLOT_W'(CMP_W'(res_slot_ff));
         rsp_data_ff   <= DATA_W'(res_data_ff);
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_result_slot  = rsp_slot_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_record_count = rsp_count_ff;

   rsfl_store #(
      .SLOTS       (SLOTS),
      .RECORD_BITS (RECORD_BITS)
   ) u_store (
      .clock       (clock),
      .ctl         (st_ctl),
      .wr_addr     (wr_addr),
      .rd_addr     (addr_ff),
      .tbl_wr_used (tbl_wr_used),
      .tbl_wr_link (tbl_wr_link),
      .rec_wr_data (wdata_ff),
      .tbl_rd_used (tbl_rd_used),
      .tbl_rd_link (tbl_rd_link),
      .rec_rd_data (rec_rd_data)
   );

endmodule

[tb/record_slot_free_list_allocator_tb.sv]
// record_slot_free_list_allocator_tb: self-checking bench for the record slot allocator.
// Depends on rsfl_pkg and the record_slot_free_list_allocator RTL; no files or arguments.
// A shadow page (flags, free chain, records) predicts every response, which is checked in order.
module record_slot_free_list_allocator_tb;
   import rsfl_pkg::*;

   localparam int NSLOTS        = 64;
   localparam int LINK_END      = NSLOTS;     // free chain end mark
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int LONG_HOLD     = 300;        // receiver back-pressure stretch
   localparam int TAIL_CYCLES   = 200;        // covers a full scan after the last response
   localparam int BACKLOG_DEPTH = 4;          // keeps generation close to the shadow page

   // ops the block decodes as no-ops
   localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

   typedef struct {
      logic [OP_W-1:0]          op;
      logic signed [SLOT_W-1:0] slot;
      logic [DATA_W-1:0]        data;
   } page_req_type;

   typedef struct {
      logic [STATUS_W-1:0] status;
      logic [RSLOT_W-1:0]  rslot;
      logic [DATA_W-1:0]   rdata;
      logic [COUNT_W-1:0]  count;
   } page_rsp_type;

   // ---------------------------------------------------------------------
   // DUT signals; the bench-driven ones are known from time zero
   // ---------------------------------------------------------------------
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CFG_W-1:0]         csr_write_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [OP_W-1:0]          req_op = '0;
   logic signed [SLOT_W-1:0] req_slot = '0;
   logic [DATA_W-1:0]        req_write_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic [RSLOT_W-1:0]       rsp_result_slot;
   logic [DATA_W-1:0]        rsp_read_data;
   logic [COUNT_W-1:0]       rsp_record_count;

   record_slot_free_list_allocator uut (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_slot         (req_slot),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_result_slot  (rsp_result_slot),
      .rsp_read_data    (rsp_read_data),
      .rsp_record_count (rsp_record_count)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Shadow page. Updated at each request transfer, so by the time a
   // response shows up its expectation is already at the head of the queue.
   // ---------------------------------------------------------------------
   logic               slot_used  [NSLOTS];
   logic [COUNT_W-1:0] free_link  [NSLOTS];
   logic [DATA_W-1:0]  record_mem [NSLOTS];
   logic [COUNT_W-1:0] free_head;
   logic [COUNT_W-1:0] used_count;
   logic [CFG_W-1:0]   page_cfg;

   page_rsp_type page_results_due [$];
   page_req_type req_backlog [$];

   int  reqs_queued = 0;    // bumped by the stimulus process
   int  reqs_taken  = 0;    // bumped by the driver
   int  mismatches  = 0;    // bumped by the monitor
   int  hold_asks   = 0;    // stimulus asks for a long receiver stall
   int  hold_done   = 0;
   bit  send_busy   = 1'b0; // 0: back-to-back offers, 1: random gaps
   bit  recv_busy   = 1'b0;

   // active slot count: csr value clamped to 1..NSLOTS
   function automatic int slot_limit();
      int v;
      v = int'(page_cfg);
      if (v < 1) v = 1;
      if (v > NSLOTS) v = NSLOTS;
      return v;
   endfunction

   // init: all slots free, chain 0 -> 1 -> ... -> limit-1 -> end
   function automatic void rebuild_free_chain();
      int lim;
      lim = slot_limit();
      for (int i = 0; i < NSLOTS; i++) begin
         slot_used[i] = 1'b0;
         free_link[i] = COUNT_W'(i + 1);
      end
      free_link[lim-1] = COUNT_W'(LINK_END);
      free_head = '0;
      used_count = '0;
   endfunction

   function automatic page_rsp_type page_op_outcome(input page_req_type it);
      page_rsp_type r;
      int        lim;
      int        cur;
      int        h;
      bit        found;
      lim = slot_limit();
      cur = int'(it.slot);      // sign-extended
      r.status = STAT_OK;
      r.rslot = '0;
      r.rdata = '0;
      case (it.op)
         OP_INIT: rebuild_free_chain();
         OP_INSERT: begin
            h = int'(free_head);
            // full count, end mark at head, or a head stranded past a lowered limit
            if (used_count >= lim || h >= lim) begin
               r.status = STAT_FULL;
            end else if (slot_used[h]) begin
               r.status = STAT_FULL;
            end else begin
               free_head = free_link[h];
               slot_used[h] = 1'b1;
               record_mem[h] = it.data;
               used_count = used_count + COUNT_W'(1);
               r.rslot = RSLOT_W'(h);
            end
         end
         OP_DELETE, OP_GET, OP_UPDATE: begin
            if (cur < 0 || cur >= lim) begin
               r.status = STAT_RANGE;
            end else if (!slot_used[cur]) begin
               r.status = STAT_NOT_IN_USE;     // double delete lands here too
            end else if (it.op == OP_DELETE) begin
               slot_used[cur] = 1'b0;
               free_link[cur] = free_head;     // push on the old head
               free_head = COUNT_W'(cur);
               if (used_count > 0) used_count = used_count - COUNT_W'(1);
            end else if (it.op == OP_GET) begin
               r.rdata = record_mem[cur];
            end else begin
               record_mem[cur] = it.data;
            end
         end
         OP_SCAN: begin
            // negative cursor starts at slot 0, otherwise the slot after it
            r.status = STAT_EOF;
            found = 1'b0;
            for (int s = (cur < 0) ? 0 : cur + 1; s < lim; s++) begin
               if (!found && slot_used[s]) begin
                  found = 1'b1;
                  r.status = STAT_OK;
                  r.rslot = RSLOT_W'(s);
                  r.rdata = record_mem[s];
               end
            end
         end
         default: ;                            // spare ops change nothing
      endcase
      r.count = used_count;
      return r;
   endfunction

   function automatic int pick_wait(input bit busy);
      return busy ? int'($urandom_range(0, 19)) : 0;
   endfunction

   // ---------------------------------------------------------------------
   // Request driver: one item at a time from the backlog, valid held until
   // the transfer, a drawn gap after each item.
   // ---------------------------------------------------------------------
   page_req_type req_now;
   int        req_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            page_results_due.push_back(page_op_outcome(req_now));
            reqs_taken++;
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (req_backlog.size() > 0) begin
               req_now = req_backlog.pop_front();
               req_op <= req_now.op;
               req_slot <= req_now.slot;
               req_write_data <= req_now.data;
               req_valid <= 1'b1;
               req_gap = pick_wait(send_busy);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: checks each transfer against the oldest expectation,
   // then draws a stall. A long hold request overrides the normal stall.
   // ---------------------------------------------------------------------
   page_rsp_type due;
   int        rsp_wait  = 0;
   int        hold_left = 0;

   task automatic check_field(input string what, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (page_results_due.size() == 0) begin
               $display("%0t: response with nothing expected, status %0d slot %0d",
                        $time, rsp_status, rsp_result_slot);
               mismatches++;
            end else begin
               due = page_results_due.pop_front();
               check_field("status", DATA_W'(due.status), DATA_W'(rsp_status));
               check_field("result_slot", DATA_W'(due.rslot), DATA_W'(rsp_result_slot));
               check_field("read_data", due.rdata, rsp_read_data);
               check_field("record_count", DATA_W'(due.count), DATA_W'(rsp_record_count));
            end
            rsp_wait = pick_wait(recv_busy);
         end
         if (hold_done != hold_asks) begin
            hold_done = hold_asks;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic queue_req(input logic [OP_W-1:0] op, input logic signed [SLOT_W-1:0] slot,
                            input logic [DATA_W-1:0] data);
      page_req_type it;
      while (req_backlog.size() >= BACKLOG_DEPTH) @(posedge clock);
      it.op = op;
      it.slot = slot;
      it.data = data;
      req_backlog.push_back(it);
      reqs_queued++;
   endtask

   // every queued request transferred and every response back
   task automatic drain();
      while (reqs_taken != reqs_queued || page_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_slot_limit(input logic [CFG_W-1:0] v);
      drain();
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_write_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      page_cfg = v;
   endtask

   // a slot currently in use in the shadow page, else any active slot
   function automatic int pick_live_slot(input int lim);
      int hits [$];
      for (int i = 0; i < lim; i++)
         if (slot_used[i]) hits.push_back(i);
      if (hits.size() == 0) return int'($urandom_range(0, lim - 1));
      return hits[$urandom_range(0, hits.size() - 1)];
   endfunction

   function automatic logic signed [SLOT_W-1:0] pick_slot(input logic [OP_W-1:0] op,
                                                         input int lim);
      int r;
      r = int'($urandom_range(0, 99));
      if (op == OP_SCAN) begin
         if (r < 20) return -1;
         if (r < 55) return SLOT_W'(pick_live_slot(lim));
         if (r < 65) return SLOT_W'(pick_live_slot(lim) - 1);
         if (r < 95) return SLOT_W'($urandom_range(0, NSLOTS - 1));
         return SLOT_W'($urandom_range(64, 126));      // raw pattern of -64..-2
      end
      if (op == OP_DELETE || op == OP_GET || op == OP_UPDATE) begin
         if (r < 70) return SLOT_W'(pick_live_slot(lim));
         if (r < 88) return SLOT_W'($urandom_range(0, lim - 1));
         if (r < 94 && lim < NSLOTS) return SLOT_W'($urandom_range(lim, NSLOTS - 1));
         if (r < 97) return -1;
         return SLOT_W'($urandom_range(0, 127));
      end
      return SLOT_W'($urandom);                        // slot is a don't-care here
   endfunction

   function automatic logic [DATA_W-1:0] pick_record();
      int r;
      r = int'($urandom_range(0, 19));
      if (r == 0) return '0;
      if (r == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   // random traffic; insert and delete weights steer the fill level
   task automatic churn(input int n, input int ins_pct, input int del_pct,
                        input bit hold_midway);
      logic [OP_W-1:0] op;
      int              r;
      for (int k = 0; k < n; k++) begin
         r = int'($urandom_range(0, 99));
         if (r == 0) op = OP_INIT;
         else if (r == 1) op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
         else if (r < 2 + ins_pct) op = OP_INSERT;
         else if (r < 2 + ins_pct + del_pct) op = OP_DELETE;
         else begin
            case ($urandom_range(0, 2))
               0:       op = OP_GET;
               1:       op = OP_UPDATE;
               default: op = OP_SCAN;
            endcase
         end
         queue_req(op, pick_slot(op, slot_limit()), pick_record());
         if (hold_midway && k == n / 2) begin
            send_busy = 1'b0;               // keep offering while the output is blocked
            hold_asks++;
         end
         if (k % 64 == 63) begin
            send_busy = 1'($urandom_range(0, 1));
            recv_busy = 1'($urandom_range(0, 1));
         end
      end
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] cfg, input bit fresh, input int n,
                            input int ins_pct, input int del_pct, input bit hold_midway);
      write_slot_limit(cfg);
      send_busy = 1'($urandom_range(0, 1));
      recv_busy = 1'($urandom_range(0, 1));
      if (fresh) queue_req(OP_INIT, SLOT_W'($urandom), pick_record());
      churn(n, ins_pct, del_pct, hold_midway);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      page_cfg = CFG_RESET;
      rebuild_free_chain();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: page of 64 straight out of reset
      queue_req(OP_GET, 0, '0);                     // free slot
      queue_req(OP_SCAN, -1, '0);                   // empty page, end of scan
      queue_req(OP_INSERT, 0, '1);                  // slot 0
      queue_req(OP_INSERT, 0, '0);                  // slot 1
      queue_req(OP_INSERT, 0, 64'hA5A5_5A5A_C3C3_3C3C);
      queue_req(OP_GET, 0, '0);
      queue_req(OP_GET, 1, '0);
      queue_req(OP_UPDATE, 1, 64'h0123_4567_89AB_CDEF);
      queue_req(OP_GET, 1, '0);
      queue_req(OP_SCAN, -1, '0);
      queue_req(OP_SCAN, 0, '0);
      queue_req(OP_SCAN, 2, '0);                    // nothing after the last used slot
      queue_req(OP_SCAN, 63, '0);                   // cursor on the last slot
      queue_req(OP_SCAN, -64, '0);                  // most negative cursor
      queue_req(OP_DELETE, 1, '0);
      queue_req(OP_DELETE, 1, '0);                  // double delete
      queue_req(OP_GET, -1, '0);                    // negative target
      queue_req(OP_UPDATE, 63, '1);                 // top slot, free
      queue_req(OP_INSERT, 0, 64'hFFFF_0000_FFFF_0000);  // reuses slot 1
      queue_req(OP_SPARE6, 0, '1);
      queue_req(OP_SPARE7, -1, '1);
      queue_req(OP_INIT, 0, '0);
      queue_req(OP_SCAN, -1, '0);

      // directed: free head stranded above a lowered limit
      for (int i = 0; i < 10; i++) queue_req(OP_INSERT, 0, pick_record());
      for (int i = 0; i < 8; i++) queue_req(OP_DELETE, SLOT_W'(i), '0);   // head ends on slot 7
      write_slot_limit(7'd5);
      queue_req(OP_INSERT, 0, '1);                  // full though count is 2
      queue_req(OP_GET, 8, '0);                     // used but past the limit
      queue_req(OP_GET, 1, '0);
      queue_req(OP_SCAN, -1, '0);                   // used slots hidden by the limit
      queue_req(OP_DELETE, 9, '0);
      write_slot_limit(7'd64);
      queue_req(OP_INSERT, 0, 64'h8000_0000_0000_0001);
      queue_req(OP_SCAN, -1, '0);

      // random phases over several limits, clamped values among them
      run_phase(7'd1,   1'b1,  40, 40, 20, 1'b0);
      run_phase(7'd5,   1'b1,  80, 35, 25, 1'b0);
      run_phase(7'd64,  1'b1, 200, 55, 15, 1'b1);
      run_phase(7'd0,   1'b0,  40, 40, 30, 1'b0);
      run_phase(7'd127, 1'b0, 100, 30, 35, 1'b0);
      run_phase(7'd17,  1'b1, 150, 40, 25, 1'b0);
      run_phase(7'd2,   1'b1,  60, 40, 30, 1'b0);
      run_phase(7'd33,  1'b0, 120, 35, 30, 1'b1);
      run_phase(7'd64,  1'b1, 200, 45, 25, 1'b0);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);   // catch any stray response
      if (mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // run limit
   int cycles = 0;

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: run limit reached, %0d responses outstanding", $time,
               page_results_due.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
